/* rtl/riscvid_pkg.sv */
// ----------------------------------------------------------------------------
// riscvid_pkg
// Opcodes, operation numbers and format classes for the instruction decoder.
// ----------------------------------------------------------------------------
package riscvid_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned OP_W   = 6;
	localparam int unsigned REG_W  = 5;
	localparam int unsigned IMM_W  = 21;

	// Major opcodes, bits 6..0 of the instruction word.
	localparam logic [6:0] OPC_REG    = 7'h33;
	localparam logic [6:0] OPC_IMM    = 7'h13;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_JAL    = 7'h6F;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;
	localparam logic [6:0] OPC_CUSTOM = 7'h2B;

	// funct7 values that select a variant.
	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_MULD = 7'h01;
	localparam logic [6:0] F7_ALT  = 7'h20;

	// funct3 values.
	localparam logic [2:0] F3_0 = 3'd0;
	localparam logic [2:0] F3_1 = 3'd1;
	localparam logic [2:0] F3_2 = 3'd2;
	localparam logic [2:0] F3_4 = 3'd4;
	localparam logic [2:0] F3_5 = 3'd5;
	localparam logic [2:0] F3_6 = 3'd6;
	localparam logic [2:0] F3_7 = 3'd7;

	// Shift-immediate selector, bits 31..30.
	localparam logic [1:0] SH_LOGIC = 2'b00;
	localparam logic [1:0] SH_ARITH = 2'b01;

	// Operation numbers.
	localparam logic [OP_W-1:0] OP_INVALID = 6'd0;
	localparam logic [OP_W-1:0] OP_ADD   = 6'd1;
	localparam logic [OP_W-1:0] OP_MUL   = 6'd2;
	localparam logic [OP_W-1:0] OP_SUB   = 6'd3;
	localparam logic [OP_W-1:0] OP_SLL   = 6'd4;
	localparam logic [OP_W-1:0] OP_MULH  = 6'd5;
	localparam logic [OP_W-1:0] OP_SLT   = 6'd6;
	localparam logic [OP_W-1:0] OP_XOR   = 6'd7;
	localparam logic [OP_W-1:0] OP_DIV   = 6'd8;
	localparam logic [OP_W-1:0] OP_SRL   = 6'd9;
	localparam logic [OP_W-1:0] OP_SRA   = 6'd10;
	localparam logic [OP_W-1:0] OP_OR    = 6'd11;
	localparam logic [OP_W-1:0] OP_REM   = 6'd12;
	localparam logic [OP_W-1:0] OP_AND   = 6'd13;
	localparam logic [OP_W-1:0] OP_ADDI  = 6'd14;
	localparam logic [OP_W-1:0] OP_SLLI  = 6'd15;
	localparam logic [OP_W-1:0] OP_SLTI  = 6'd16;
	localparam logic [OP_W-1:0] OP_XORI  = 6'd17;
	localparam logic [OP_W-1:0] OP_SRLI  = 6'd18;
	localparam logic [OP_W-1:0] OP_SRAI  = 6'd19;
	localparam logic [OP_W-1:0] OP_ORI   = 6'd20;
	localparam logic [OP_W-1:0] OP_ANDI  = 6'd21;
	localparam logic [OP_W-1:0] OP_LB    = 6'd22;
	localparam logic [OP_W-1:0] OP_LH    = 6'd23;
	localparam logic [OP_W-1:0] OP_LW    = 6'd24;
	localparam logic [OP_W-1:0] OP_SB    = 6'd25;
	localparam logic [OP_W-1:0] OP_SH    = 6'd26;
	localparam logic [OP_W-1:0] OP_SW    = 6'd27;
	localparam logic [OP_W-1:0] OP_BEQ   = 6'd28;
	localparam logic [OP_W-1:0] OP_BNE   = 6'd29;
	localparam logic [OP_W-1:0] OP_LUI   = 6'd30;
	localparam logic [OP_W-1:0] OP_JAL   = 6'd31;
	localparam logic [OP_W-1:0] OP_ECALL = 6'd32;
	localparam logic [OP_W-1:0] OP_MAC   = 6'd33;
	localparam logic [OP_W-1:0] OP_ACC   = 6'd34;
	localparam logic [OP_W-1:0] OP_GEP   = 6'd35;

	// Encoding format, which decides how the fields are assembled.
	typedef enum logic [3:0] {
		FMT_NONE,
		FMT_R,
		FMT_I,
		FMT_SHIFT,
		FMT_S,
		FMT_B,
		FMT_U,
		FMT_J,
		FMT_SYS
	} fmt_t;

endpackage

/* rtl/riscv_instruction_decoder.sv */
// ----------------------------------------------------------------------------
// riscv_instruction_decoder
// Three-stage pipelined RV32IM decoder with the custom mac/acc/gep opcode.
// ----------------------------------------------------------------------------
// Usage:
//   An instruction word is transferred at a rising edge where start is high
//   and busy is low. busy is held low, so a new word may be given on every
//   cycle.
//   Each word gives exactly one result: op_id, dest_reg, src_reg_a,
//   src_reg_b and imm_value, shown for one cycle while done is high.
//   A word passes through three register stages (capture, opcode decode,
//   field assembly) before its result is on the result ports. Throughput is
//   one word per cycle.
//   The receiver cannot stall, so no back-pressure is applied and nothing
//   is held back.
//   An asynchronous reset (arst_n low) clears the valid bits of every stage;
//   words in flight are dropped and done stays low until new work arrives.
//   op_id 0 marks an invalid word, with every other field set to zero.
// ----------------------------------------------------------------------------
module riscv_instruction_decoder
	import riscvid_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [WORD_W-1:0]       instr_word,
	output logic                    done,
	output logic [OP_W-1:0]         op_id,
	output logic [REG_W-1:0]        dest_reg,
	output logic [REG_W-1:0]        src_reg_a,
	output logic [REG_W-1:0]        src_reg_b,
	output logic signed [IMM_W-1:0] imm_value
);

	// Stage 1: captured word.
	logic              vld_s1;
	logic [WORD_W-1:0] word_s1;

	// Stage 2: operation number and format.
	logic              vld_s2;
	logic [WORD_W-1:0] word_s2;
	logic [OP_W-1:0]   op_s2;
	fmt_t              fmt_s2;

	// Stage 3: assembled result.
	logic                    vld_s3;
	logic [OP_W-1:0]         op_s3;
	logic [REG_W-1:0]        rd_s3;
	logic [REG_W-1:0]        rs1_s3;
	logic [REG_W-1:0]        rs2_s3;
	logic signed [IMM_W-1:0] imm_s3;

	logic [OP_W-1:0]         op_d;
	fmt_t                    fmt_d;
	logic [REG_W-1:0]        rd_d;
	logic [REG_W-1:0]        rs1_d;
	logic [REG_W-1:0]        rs2_d;
	logic signed [IMM_W-1:0] imm_d;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		word_s1 <= instr_word;
		word_s2 <= word_s1;
		op_s2   <= op_d;
		fmt_s2  <= fmt_d;
		op_s3   <= op_s2;
		rd_s3   <= rd_d;
		rs1_s3  <= rs1_d;
		rs2_s3  <= rs2_d;
		imm_s3  <= imm_d;
	end

	// Opcode and funct decode.
	always_comb begin
		logic [6:0] opc;
		logic [2:0] f3;
		logic [6:0] f7;
		opc   = word_s1[6:0];
		f3    = word_s1[14:12];
		f7    = word_s1[31:25];
		op_d  = OP_INVALID;
		fmt_d = FMT_NONE;
		unique case (opc)
			OPC_REG: begin
				fmt_d = FMT_R;
				unique case (f3)
					F3_0: op_d = (f7 == F7_BASE) ? OP_ADD :
					             (f7 == F7_MULD) ? OP_MUL :
					             (f7 == F7_ALT)  ? OP_SUB : OP_INVALID;
					F3_1: op_d = (f7 == F7_BASE) ? OP_SLL :
					             (f7 == F7_MULD) ? OP_MULH : OP_INVALID;
					F3_2: op_d = OP_SLT;
					F3_4: op_d = (f7 == F7_BASE) ? OP_XOR :
					             (f7 == F7_MULD) ? OP_DIV : OP_INVALID;
					F3_5: op_d = (f7 == F7_BASE) ? OP_SRL :
					             (f7 == F7_ALT)  ? OP_SRA : OP_INVALID;
					F3_6: op_d = (f7 == F7_BASE) ? OP_OR :
					             (f7 == F7_MULD) ? OP_REM : OP_INVALID;
					F3_7: op_d = OP_AND;
					default: op_d = OP_INVALID;
				endcase
			end
			OPC_IMM: begin
				fmt_d = FMT_I;
				unique case (f3)
					F3_0: op_d = OP_ADDI;
					F3_1: op_d = OP_SLLI;
					F3_2: op_d = OP_SLTI;
					F3_4: op_d = OP_XORI;
					F3_5: begin
						fmt_d = FMT_SHIFT;
						op_d  = (word_s1[31:30] == SH_LOGIC) ? OP_SRLI :
						        (word_s1[31:30] == SH_ARITH) ? OP_SRAI : OP_INVALID;
					end
					F3_6: op_d = OP_ORI;
					F3_7: op_d = OP_ANDI;
					default: op_d = OP_INVALID;
				endcase
			end
			OPC_LOAD: begin
				fmt_d = FMT_I;
				unique case (f3)
					F3_0: op_d = OP_LB;
					F3_1: op_d = OP_LH;
					F3_2: op_d = OP_LW;
					default: op_d = OP_INVALID;
				endcase
			end
			OPC_STORE: begin
				fmt_d = FMT_S;
				unique case (f3)
					F3_0: op_d = OP_SB;
					F3_1: op_d = OP_SH;
					F3_2: op_d = OP_SW;
					default: op_d = OP_INVALID;
				endcase
			end
			OPC_BRANCH: begin
				fmt_d = FMT_B;
				unique case (f3)
					F3_0: op_d = OP_BEQ;
					F3_1: op_d = OP_BNE;
					default: op_d = OP_INVALID;
				endcase
			end
			OPC_LUI: begin
				fmt_d = FMT_U;
				op_d  = OP_LUI;
			end
			OPC_JAL: begin
				fmt_d = FMT_J;
				op_d  = OP_JAL;
			end
			OPC_SYSTEM: begin
				fmt_d = FMT_SYS;
				op_d  = OP_ECALL;
			end
			OPC_CUSTOM: begin
				fmt_d = FMT_R;
				unique case (f3)
					F3_0: op_d = OP_MAC;
					F3_1: op_d = OP_ACC;
					F3_2: op_d = OP_GEP;
					default: op_d = OP_INVALID;
				endcase
			end
			default: begin
				fmt_d = FMT_NONE;
				op_d  = OP_INVALID;
			end
		endcase
	end

	// Field assembly. An invalid operation clears every field.
	always_comb begin
		rd_d  = '0;
		rs1_d = '0;
		rs2_d = '0;
		imm_d = '0;
		if (op_s2 != OP_INVALID) begin
			unique case (fmt_s2)
				FMT_R: begin
					rd_d  = word_s2[11:7];
					rs1_d = word_s2[19:15];
					rs2_d = word_s2[24:20];
				end
				FMT_I: begin
					rd_d  = word_s2[11:7];
					rs1_d = word_s2[19:15];
					imm_d = {{(IMM_W-12){word_s2[31]}}, word_s2[31:20]};
				end
				FMT_SHIFT: begin
					rd_d  = word_s2[11:7];
					rs1_d = word_s2[19:15];
					imm_d = {{(IMM_W-5){1'b0}}, word_s2[24:20]};
				end
				FMT_S: begin
					rs1_d = word_s2[19:15];
					rs2_d = word_s2[24:20];
					imm_d = {{(IMM_W-12){word_s2[31]}}, word_s2[31:25], word_s2[11:7]};
				end
				FMT_B: begin
					rs1_d = word_s2[19:15];
					rs2_d = word_s2[24:20];
					imm_d = {{(IMM_W-13){word_s2[31]}}, word_s2[31], word_s2[7],
					         word_s2[30:25], word_s2[11:8], 1'b0};
				end
				FMT_U: begin
					rd_d  = word_s2[11:7];
					imm_d = {1'b0, word_s2[31:12]};
				end
				FMT_J: begin
					rd_d  = word_s2[11:7];
					imm_d = {word_s2[31], word_s2[19:12], word_s2[20],
					         word_s2[30:21], 1'b0};
				end
				FMT_SYS, FMT_NONE: begin
					rd_d = '0;
				end
				default: begin
					rd_d = '0;
				end
			endcase
		end
	end

	assign done      = vld_s3;
	assign op_id     = op_s3;
	assign dest_reg  = rd_s3;
	assign src_reg_a = rs1_s3;
	assign src_reg_b = rs2_s3;
	assign imm_value = imm_s3;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RV32IM instruction decoder. A short table of
// hand-picked words comes first: the all-zero and all-one words, the field
// extremes and the loosely checked funct7 and shift encodings. After that,
// mostly well-formed random words of every operation are sent, with some
// noise. Each decoded result is compared field by field with the row's typed result or a local decoder.
// ----------------------------------------------------------------------------
module tb_top
	import riscvid_pkg::*;
();

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RAND_ITEMS  = 1400;
	localparam int unsigned DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [OP_W-1:0]         op;
		logic [REG_W-1:0]        rd;
		logic [REG_W-1:0]        rs1;
		logic [REG_W-1:0]        rs2;
		logic signed [IMM_W-1:0] imm;
	} decoded_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              typed;
		decoded_t          want;
	} stim_row_t;

	localparam decoded_t NO_FIELDS = '0;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic [WORD_W-1:0]       instr_word = '0;
	logic                    busy;
	logic                    done;
	logic [OP_W-1:0]         op_id;
	logic [REG_W-1:0]        dest_reg;
	logic [REG_W-1:0]        src_reg_a;
	logic [REG_W-1:0]        src_reg_b;
	logic signed [IMM_W-1:0] imm_value;

	// Travels alongside each word so that the monitor knows which expectation to queue.
	logic     drive_typed = 1'b0;
	decoded_t drive_want = '0;

	decoded_t    pending_decodes[$];
	stim_row_t   directed_rows[$];
	int unsigned err_count = 0;
	int unsigned result_count = 0;
	int unsigned invalid_count = 0;
	int unsigned cycle_count = 0;
	bit          ops_seen[64];

	riscv_instruction_decoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.instr_word(instr_word),
		.done(done),
		.op_id(op_id),
		.dest_reg(dest_reg),
		.src_reg_a(src_reg_a),
		.src_reg_b(src_reg_b),
		.imm_value(imm_value)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic decoded_t decode_word(input logic [WORD_W-1:0] w);
		decoded_t    d;
		logic [6:0]  opc;
		logic [6:0]  f7;
		logic [2:0]  f3;
		logic [12:0] boff;
		d   = '0;
		opc = w[6:0];
		f3  = w[14:12];
		f7  = w[31:25];
		case (opc)
			OPC_REG: begin
				d.rd  = w[11:7];
				d.rs1 = w[19:15];
				d.rs2 = w[24:20];
				case (f3)
					F3_0: d.op = (f7 == F7_BASE) ? OP_ADD : (f7 == F7_MULD) ? OP_MUL :
						(f7 == F7_ALT) ? OP_SUB : OP_INVALID;
					F3_1: d.op = (f7 == F7_BASE) ? OP_SLL : (f7 == F7_MULD) ? OP_MULH : OP_INVALID;
					F3_2: d.op = OP_SLT;
					F3_4: d.op = (f7 == F7_BASE) ? OP_XOR : (f7 == F7_MULD) ? OP_DIV : OP_INVALID;
					F3_5: d.op = (f7 == F7_BASE) ? OP_SRL : (f7 == F7_ALT) ? OP_SRA : OP_INVALID;
					F3_6: d.op = (f7 == F7_BASE) ? OP_OR : (f7 == F7_MULD) ? OP_REM : OP_INVALID;
					F3_7: d.op = OP_AND;
					default: d.op = OP_INVALID;
				endcase
			end
			OPC_IMM: begin
				d.rd  = w[11:7];
				d.rs1 = w[19:15];
				d.imm = {{9{w[31]}}, w[31:20]};
				case (f3)
					F3_0: d.op = OP_ADDI;
					F3_1: d.op = OP_SLLI;
					F3_2: d.op = OP_SLTI;
					F3_4: d.op = OP_XORI;
					F3_5: begin
						d.op  = (w[31:30] == SH_LOGIC) ? OP_SRLI :
							(w[31:30] == SH_ARITH) ? OP_SRAI : OP_INVALID;
						d.imm = {16'd0, w[24:20]};
					end
					F3_6: d.op = OP_ORI;
					F3_7: d.op = OP_ANDI;
					default: d.op = OP_INVALID;
				endcase
			end
			OPC_LOAD: begin
				d.rd  = w[11:7];
				d.rs1 = w[19:15];
				d.imm = {{9{w[31]}}, w[31:20]};
				d.op  = (f3 == F3_0) ? OP_LB : (f3 == F3_1) ? OP_LH :
					(f3 == F3_2) ? OP_LW : OP_INVALID;
			end
			OPC_STORE: begin
				d.rs1 = w[19:15];
				d.rs2 = w[24:20];
				d.imm = {{9{w[31]}}, w[31:25], w[11:7]};
				d.op  = (f3 == F3_0) ? OP_SB : (f3 == F3_1) ? OP_SH :
					(f3 == F3_2) ? OP_SW : OP_INVALID;
			end
			OPC_BRANCH: begin
				d.rs1 = w[19:15];
				d.rs2 = w[24:20];
				boff  = {w[31], w[7], w[30:25], w[11:8], 1'b0};
				d.imm = {{8{boff[12]}}, boff};
				d.op  = (f3 == F3_0) ? OP_BEQ : (f3 == F3_1) ? OP_BNE : OP_INVALID;
			end
			OPC_LUI: begin
				d.op  = OP_LUI;
				d.rd  = w[11:7];
				d.imm = {1'b0, w[31:12]};
			end
			OPC_JAL: begin
				d.op  = OP_JAL;
				d.rd  = w[11:7];
				d.imm = {w[31], w[19:12], w[20], w[30:21], 1'b0};
			end
			OPC_SYSTEM: d.op = OP_ECALL;
			OPC_CUSTOM: begin
				d.rd  = w[11:7];
				d.rs1 = w[19:15];
				d.rs2 = w[24:20];
				d.op  = (f3 == F3_0) ? OP_MAC : (f3 == F3_1) ? OP_ACC :
					(f3 == F3_2) ? OP_GEP : OP_INVALID;
			end
			default: d.op = OP_INVALID;
		endcase
		if (d.op == OP_INVALID)
			d = '0;
		return d;
	endfunction

	function automatic logic [WORD_W-1:0] r_word(input logic [WORD_W-1:0] r,
			input logic [2:0] f3, input logic [6:0] f7);
		return {f7, r[24:15], f3, r[11:7], OPC_REG};
	endfunction

	function automatic logic [WORD_W-1:0] i_word(input logic [WORD_W-1:0] r,
			input logic [6:0] opc, input logic [2:0] f3);
		return {r[31:15], f3, r[11:7], opc};
	endfunction

	// Builds a well-formed word for the given operation; all other bits come from r.
	function automatic logic [WORD_W-1:0] encode_op(input logic [OP_W-1:0] op,
			input logic [WORD_W-1:0] r);
		case (op)
			OP_ADD:   return r_word(r, F3_0, F7_BASE);
			OP_MUL:   return r_word(r, F3_0, F7_MULD);
			OP_SUB:   return r_word(r, F3_0, F7_ALT);
			OP_SLL:   return r_word(r, F3_1, F7_BASE);
			OP_MULH:  return r_word(r, F3_1, F7_MULD);
			OP_SLT:   return r_word(r, F3_2, r[31:25]);
			OP_XOR:   return r_word(r, F3_4, F7_BASE);
			OP_DIV:   return r_word(r, F3_4, F7_MULD);
			OP_SRL:   return r_word(r, F3_5, F7_BASE);
			OP_SRA:   return r_word(r, F3_5, F7_ALT);
			OP_OR:    return r_word(r, F3_6, F7_BASE);
			OP_REM:   return r_word(r, F3_6, F7_MULD);
			OP_AND:   return r_word(r, F3_7, r[31:25]);
			OP_ADDI:  return i_word(r, OPC_IMM, F3_0);
			OP_SLLI:  return i_word(r, OPC_IMM, F3_1);
			OP_SLTI:  return i_word(r, OPC_IMM, F3_2);
			OP_XORI:  return i_word(r, OPC_IMM, F3_4);
			OP_SRLI:  return {SH_LOGIC, r[29:15], F3_5, r[11:7], OPC_IMM};
			OP_SRAI:  return {SH_ARITH, r[29:15], F3_5, r[11:7], OPC_IMM};
			OP_ORI:   return i_word(r, OPC_IMM, F3_6);
			OP_ANDI:  return i_word(r, OPC_IMM, F3_7);
			OP_LB:    return i_word(r, OPC_LOAD, F3_0);
			OP_LH:    return i_word(r, OPC_LOAD, F3_1);
			OP_LW:    return i_word(r, OPC_LOAD, F3_2);
			OP_SB:    return i_word(r, OPC_STORE, F3_0);
			OP_SH:    return i_word(r, OPC_STORE, F3_1);
			OP_SW:    return i_word(r, OPC_STORE, F3_2);
			OP_BEQ:   return i_word(r, OPC_BRANCH, F3_0);
			OP_BNE:   return i_word(r, OPC_BRANCH, F3_1);
			OP_LUI:   return {r[31:7], OPC_LUI};
			OP_JAL:   return {r[31:7], OPC_JAL};
			OP_ECALL: return {r[31:7], OPC_SYSTEM};
			OP_MAC:   return i_word(r, OPC_CUSTOM, F3_0);
			OP_ACC:   return i_word(r, OPC_CUSTOM, F3_1);
			OP_GEP:   return i_word(r, OPC_CUSTOM, F3_2);
			default:  return r;
		endcase
	endfunction

	function automatic logic [6:0] pick_opcode();
		case ($urandom_range(8))
			0: return OPC_REG;
			1: return OPC_IMM;
			2: return OPC_LOAD;
			3: return OPC_STORE;
			4: return OPC_BRANCH;
			5: return OPC_LUI;
			6: return OPC_JAL;
			7: return OPC_SYSTEM;
			default: return OPC_CUSTOM;
		endcase
	endfunction

	// Mostly well-formed words; the rest are a known opcode over random bits,
	// which reaches the unused funct3 and funct7 codes, or a fully random word.
	function automatic logic [WORD_W-1:0] random_word();
		logic [WORD_W-1:0] r;
		int unsigned       sel;
		r   = $urandom;
		sel = $urandom_range(99);
		if (sel < 80)
			return encode_op(OP_W'($urandom_range(OP_GEP, OP_ADD)), r);
		else if (sel < 90)
			return {r[31:7], pick_opcode()};
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		err_count++;
		$display("[%0t] %s mismatch: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
	endtask

	// One word per transfer; start stays high from one transfer to the next
	// unless the sender decides to pause.
	task automatic send_word(input logic [WORD_W-1:0] w, input logic typed,
			input decoded_t want, input int unsigned gap_pct);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start       <= 1'b1;
		instr_word  <= w;
		drive_typed <= typed;
		drive_want  <= want;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Transfers and results are both taken on the pre-edge values.
	always @(posedge clk) begin
		decoded_t want;
		if (arst_n) begin
			if (start && !busy)
				pending_decodes.push_back(drive_typed ? drive_want : decode_word(instr_word));
			if (done) begin
				result_count++;
				ops_seen[op_id] = 1'b1;
				if (op_id == OP_INVALID)
					invalid_count++;
				if (pending_decodes.size() == 0) begin
					report_mismatch("unexpected result op_id", 32'(op_id), 32'd0);
				end else begin
					want = pending_decodes.pop_front();
					if (op_id !== want.op)
						report_mismatch("op_id", 32'(op_id), 32'(want.op));
					if (dest_reg !== want.rd)
						report_mismatch("dest_reg", 32'(dest_reg), 32'(want.rd));
					if (src_reg_a !== want.rs1)
						report_mismatch("src_reg_a", 32'(src_reg_a), 32'(want.rs1));
					if (src_reg_b !== want.rs2)
						report_mismatch("src_reg_b", 32'(src_reg_b), 32'(want.rs2));
					if (imm_value !== want.imm)
						report_mismatch("imm_value", 32'(imm_value), 32'(want.imm));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_decodes.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int unsigned gap_pct;
		int unsigned n;
		int unsigned distinct_ops;

		// Rows with a typed result are the ones that can be read straight off the encoding.
		directed_rows.push_back(stim_row_t'{32'h00000000, 1'b1, NO_FIELDS});
		directed_rows.push_back(stim_row_t'{32'hFFFFFFFF, 1'b1, NO_FIELDS});
		directed_rows.push_back(stim_row_t'{32'hFFFFFFF3, 1'b1,
			decoded_t'{OP_ECALL, 5'd0, 5'd0, 5'd0, 21'sd0}});
		directed_rows.push_back(stim_row_t'{32'hFFFFFFB7, 1'b1,
			decoded_t'{OP_LUI, 5'd31, 5'd0, 5'd0, 21'sd1048575}});
		directed_rows.push_back(stim_row_t'{32'h8000006F, 1'b1,
			decoded_t'{OP_JAL, 5'd0, 5'd0, 5'd0, 21'h100000}});
		directed_rows.push_back(stim_row_t'{32'h7FFFFFEF, 1'b0, NO_FIELDS});
		directed_rows.push_back(stim_row_t'{32'h01FF8FB3, 1'b0, NO_FIELDS});
		directed_rows.push_back(stim_row_t'{32'h40000033, 1'b0, NO_FIELDS});
		directed_rows.push_back(stim_row_t'{32'h02000033, 1'b0, NO_FIELDS});
		directed_rows.push_back(stim_row_t'{32'hFE000033, 1'b1, NO_FIELDS});
		// slt and and ignore funct7 altogether.
		directed_rows.push_back(stim_row_t'{32'hFE002033, 1'b0, NO_FIELDS});
		directed_rows.push_back(stim_row_t'{32'hAA007033, 1'b0, NO_FIELDS});
		directed_rows.push_back(stim_row_t'{32'h00003033, 1'b1, NO_FIELDS});
		directed_rows.push_back(stim_row_t'{32'h80000013, 1'b0, NO_FIELDS});
		// slli reports the full immediate; the shifts right look only at bits 31..30.
		directed_rows.push_back(stim_row_t'{32'hFE001093, 1'b0, NO_FIELDS});
		directed_rows.push_back(stim_row_t'{32'h3E005093, 1'b0, NO_FIELDS});
		directed_rows.push_back(stim_row_t'{32'h7FF05093, 1'b0, NO_FIELDS});
		directed_rows.push_back(stim_row_t'{32'h80005093, 1'b1, NO_FIELDS});
		directed_rows.push_back(stim_row_t'{32'h00003003, 1'b1, NO_FIELDS});
		directed_rows.push_back(stim_row_t'{32'hFE002FA3, 1'b0, NO_FIELDS});
		directed_rows.push_back(stim_row_t'{32'h00002063, 1'b1, NO_FIELDS});
		directed_rows.push_back(stim_row_t'{32'h80001063, 1'b0, NO_FIELDS});
		directed_rows.push_back(stim_row_t'{32'hFFFFA0AB, 1'b0, NO_FIELDS});
		directed_rows.push_back(stim_row_t'{32'h0000302B, 1'b1, NO_FIELDS});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want, 37);

		// Three stretches of sender behaviour: light pauses, heavy pauses, back to back.
		for (n = 0; n < RAND_ITEMS; n++) begin
			if (n < RAND_ITEMS / 3)
				gap_pct = 37;
			else if (n < 2 * RAND_ITEMS / 3)
				gap_pct = 61;
			else
				gap_pct = 0;
			send_word(random_word(), 1'b0, NO_FIELDS, gap_pct);
		end
		start <= 1'b0;

		while (pending_decodes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		distinct_ops = 0;
		foreach (ops_seen[i])
			if (ops_seen[i])
				distinct_ops++;
		$display("Decoded %0d words (%0d directed), %0d of them flagged invalid.",
			result_count, directed_rows.size(), invalid_count);
		$display("Distinct op_id values seen: %0d of 36, mismatches: %0d.",
			distinct_ops, err_count);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* files.f */
rtl/riscvid_pkg.sv
rtl/riscv_instruction_decoder.sv
tb/tb_top.sv
